### rtl/core/sliding_mode_rotor_observer_macros.svh
// Assertion helpers for the rotor observer
`ifndef SLIDING_MODE_ROTOR_OBSERVER_MACROS_SVH
`define SLIDING_MODE_ROTOR_OBSERVER_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define SMRO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define SMRO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/core/smro_pkg.sv
`default_nettype none
package smro_pkg;
    typedef struct packed {
        logic signed [15:0] v_alpha;
        logic signed [15:0] v_beta;
        logic signed [15:0] i_alpha;
        logic signed [15:0] i_beta;
    } t_in;
    typedef struct packed {
        logic [15:0]        rotor_angle;
        logic signed [23:0] window_speed;
        logic signed [23:0] filtered_speed;
        logic signed [15:0] emf_alpha;
        logic signed [15:0] emf_beta;
    } t_out;
    typedef struct packed {
        logic [14:0] plant_decay;
        logic [14:0] plant_gain;
        logic [14:0] slide_gain;
        logic [14:0] linear_error_bound;
        logic [15:0] filter_speed_scale;
        logic [14:0] filter_coef_floor;
        logic [15:0] angle_offset;
    } t_cfg;
    localparam logic [2:0] REG_PLANT_DECAY = 3'd0;
    localparam logic [2:0] REG_PLANT_GAIN  = 3'd1;
    localparam logic [2:0] REG_SLIDE_GAIN  = 3'd2;
    localparam logic [2:0] REG_ERR_BOUND   = 3'd3;
    localparam logic [2:0] REG_SPEED_SCALE = 3'd4;
    localparam logic [2:0] REG_COEF_FLOOR  = 3'd5;
    localparam logic [2:0] REG_ANGLE_OFS   = 3'd6;
    localparam logic [16:0] SMOOTH_Q16 = 17'd3277;
    localparam logic [14:0] COEF_MAX = 15'd32767;
    localparam int MAX_STEPS = 24;
    typedef logic [31:0] t_atan_tab [MAX_STEPS];
    localparam t_atan_tab ATAN_TURNS = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    // Lane command: which phase the shared per-axis sequencer is in
    typedef enum logic [2:0] {
        LC_IDLE, LC_MODEL, LC_ERR, LC_DIV, LC_LP1, LC_LP2
    } t_lane_op;
    typedef struct packed {
        t_lane_op          op;
        logic signed [15:0] v;
        logic signed [15:0] meas;
        logic [14:0]       coef;
    } t_lane_ctl;
    function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
        if (x > 48'sd32767) return 16'sh7FFF;
        if (x < -48'sd32768) return 16'sh8000;
        return x[15:0];
    endfunction
endpackage
`default_nettype wire

### rtl/core/sliding_mode_rotor_observer.sv
// Sensorless rotor observer: one input transaction gives one result after a model step,
// an error step, a serial divide of the switching term in the two axis lanes (when the
// current error lies in the linear zone), two low-pass steps, the angle CORDIC and the
// speed and coefficient update. Outside the linear zone the switching term is set in
// the error step with no divide, and a zero back-EMF vector ends the CORDIC with no
// micro-rotations. The block takes one transaction at a time and is ready again in the
// same cycle in which its result appears; a held result does not block acceptance of
// the next one, but the next result waits for it.
`default_nettype none
`include "sliding_mode_rotor_observer_macros.svh"
module sliding_mode_rotor_observer #(
    parameter int SPEED_WINDOW = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire smro_pkg::t_in    i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output smro_pkg::t_out        o_data,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_addr,
    input  wire logic [15:0]      i_cfg_wdata
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_MODEL, ST_ERR, ST_DIV, ST_LP1, ST_LP2, ST_CORDIC, ST_SPEED
    } t_state;
    t_state              r_state;
    smro_pkg::t_cfg      r_cfg;
    smro_pkg::t_in       r_in;
    smro_pkg::t_lane_ctl ctl_a, ctl_b;
    smro_pkg::t_lane_op  op;
    logic                div_a, div_b, cor_done, spd_done, r_cor_go, r_spd_go;
    logic                r_spd_hit;
    logic signed [15:0]  e2a, e2b;
    logic [15:0]         cor_ang, spd_ang;
    logic signed [23:0]  held, smooth;
    logic [14:0]         coef;

    assign o_ready = r_state == ST_IDLE;

    always_comb begin
        unique case (r_state)
            ST_MODEL: op = smro_pkg::LC_MODEL;
            ST_ERR:   op = smro_pkg::LC_ERR;
            ST_DIV:   op = smro_pkg::LC_DIV;
            ST_LP1:   op = smro_pkg::LC_LP1;
            ST_LP2:   op = smro_pkg::LC_LP2;
            default:  op = smro_pkg::LC_IDLE;
        endcase
        ctl_a = '{op: op, v: r_in.v_alpha, meas: r_in.i_alpha, coef: coef};
        ctl_b = '{op: op, v: r_in.v_beta, meas: r_in.i_beta, coef: coef};
    end

    smro_lane u_lane_a (.i_clk, .i_rst_n, .i_cfg(r_cfg), .i_ctl(ctl_a),
        .o_div_done(div_a), .o_emf2(e2a));
    smro_lane u_lane_b (.i_clk, .i_rst_n, .i_cfg(r_cfg), .i_ctl(ctl_b),
        .o_div_done(div_b), .o_emf2(e2b));
    smro_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (.i_clk, .i_rst_n,
        .i_start(r_cor_go), .i_x(e2b), .i_y(-17'(e2a)), .o_done(cor_done),
        .o_angle(cor_ang));
    smro_speed #(.SPEED_WINDOW(SPEED_WINDOW)) u_speed (.i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_start(r_spd_go), .i_raw_angle(cor_ang), .o_done(spd_done),
        .o_angle(spd_ang), .o_held(held), .o_smooth(smooth), .o_coef(coef));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{plant_decay: 15'd32000, plant_gain: 15'd1000,
                       slide_gain: 15'd16384, linear_error_bound: 15'd2000,
                       filter_speed_scale: 16'd256, filter_coef_floor: 15'd328,
                       angle_offset: 16'd0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                smro_pkg::REG_PLANT_DECAY: r_cfg.plant_decay <= i_cfg_wdata[14:0];
                smro_pkg::REG_PLANT_GAIN:  r_cfg.plant_gain <= i_cfg_wdata[14:0];
                smro_pkg::REG_SLIDE_GAIN:  r_cfg.slide_gain <= i_cfg_wdata[14:0];
                smro_pkg::REG_ERR_BOUND:   r_cfg.linear_error_bound <= i_cfg_wdata[14:0];
                smro_pkg::REG_SPEED_SCALE: r_cfg.filter_speed_scale <= i_cfg_wdata;
                smro_pkg::REG_COEF_FLOOR:  r_cfg.filter_coef_floor <= i_cfg_wdata[14:0];
                smro_pkg::REG_ANGLE_OFS:   r_cfg.angle_offset <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; o_valid <= 1'b0; r_cor_go <= 1'b0; r_spd_go <= 1'b0;
            r_spd_hit <= 1'b0;
        end else begin
            r_cor_go <= 1'b0;
            r_spd_go <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_in <= i_data;
                    r_state <= ST_MODEL;
                end
                ST_MODEL: r_state <= ST_ERR;
                ST_ERR:   r_state <= ST_DIV;
                ST_DIV:   if (div_a && div_b) r_state <= ST_LP1;
                ST_LP1:   r_state <= ST_LP2;
                ST_LP2: begin
                    r_cor_go <= 1'b1;
                    r_state <= ST_CORDIC;
                end
                ST_CORDIC: if (cor_done) begin
                    r_spd_go <= 1'b1;
                    r_state <= ST_SPEED;
                end
                ST_SPEED: if ((spd_done || r_spd_hit) && (!o_valid || i_ready)) begin
                    o_valid <= 1'b1;
                    o_data <= '{rotor_angle: spd_ang, window_speed: held,
                                filtered_speed: smooth, emf_alpha: e2a, emf_beta: e2b};
                    r_spd_hit <= 1'b0;
                    r_state <= ST_IDLE;
                end else if (spd_done) begin
                    // hold the finished update until the output slot frees
                    r_spd_hit <= 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `SMRO_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !o_ready,
        "observer ready while busy")
    `SMRO_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready,
        r_state == ST_MODEL, "accepted transaction did not start model step")
    `SMRO_ASSERT_IMP(a_coef_range, i_clk, i_rst_n, r_state == ST_LP1,
        coef <= smro_pkg::COEF_MAX, "low-pass coefficient out of range")
endmodule
`default_nettype wire

### rtl/core/smro_lane.sv
`default_nettype none
// One axis: current model, switching term (serial divide), two low-pass stages
module smro_lane (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire smro_pkg::t_cfg     i_cfg,
    input  wire smro_pkg::t_lane_ctl i_ctl,
    output logic                    o_div_done,
    output logic signed [15:0]      o_emf2
);
    logic signed [15:0] r_m, r_z, r_e1, r_e2;
    logic [29:0]        r_num;      // |slide_gain*err|, quotient builds in low bits
    logic [15:0]        r_rem;
    logic [4:0]         r_cnt;
    logic               r_neg, r_busy;
    logic signed [47:0] acc;
    logic signed [35:0] lp;
    logic signed [16:0] n_err;
    logic [16:0]        mag;
    logic [16:0]        trial;
    logic [15:0]        n_rem;

    always_comb begin
        acc = '0;
        lp = '0;
        unique case (i_ctl.op)
            smro_pkg::LC_MODEL: acc = $signed({1'b0, i_cfg.plant_decay}) * r_m
                + $signed({1'b0, i_cfg.plant_gain})
                  * (48'(i_ctl.v) - 48'(r_e1) - 48'(r_z)) + 48'sd16384;
            smro_pkg::LC_LP1: lp = $signed({1'b0, i_ctl.coef}) * (36'(r_z) - 36'(r_e1))
                + 36'sd16384;
            smro_pkg::LC_LP2: lp = $signed({1'b0, i_ctl.coef}) * (36'(r_e1) - 36'(r_e2))
                + 36'sd16384;
            default: ;
        endcase
        n_err = 17'(r_m) - 17'(i_ctl.meas);
        mag   = n_err[16] ? 17'(-n_err) : n_err;
        n_rem = 16'({r_rem[14:0], r_num[29]});
        trial = {1'b0, n_rem} - {2'b0, i_cfg.linear_error_bound};
    end
    assign o_div_done = r_cnt == 5'd0 && !r_busy;
    assign o_emf2 = r_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= '0; r_z <= '0; r_e1 <= '0; r_e2 <= '0;
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            unique case (i_ctl.op)
                smro_pkg::LC_MODEL: r_m <= smro_pkg::sat16(acc >>> 15);
                smro_pkg::LC_ERR: begin
                    if (i_cfg.linear_error_bound != '0 &&
                        mag < {2'b0, i_cfg.linear_error_bound}) begin
                        r_num  <= 30'(i_cfg.slide_gain) * 30'(mag);
                        r_neg  <= n_err[16];
                        r_rem  <= '0;
                        r_cnt  <= 5'd30;
                        r_busy <= 1'b1;
                    end else begin
                        r_z <= (n_err > 0) ? 16'($signed({1'b0, i_cfg.slide_gain}))
                                           : -16'($signed({1'b0, i_cfg.slide_gain}));
                    end
                end
                smro_pkg::LC_DIV: if (r_busy) begin
                    // restoring division, one quotient bit per cycle
                    if (!trial[16]) begin
                        r_rem <= trial[15:0];
                        r_num <= {r_num[28:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_num <= {r_num[28:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_busy <= 1'b0;
                        r_z <= r_neg ? -16'({r_num[28:0], !trial[16]})
                                     : 16'({r_num[28:0], !trial[16]});
                    end
                end
                smro_pkg::LC_LP1: r_e1 <= smro_pkg::sat16(48'(r_e1) + 48'(lp >>> 15));
                smro_pkg::LC_LP2: r_e2 <= smro_pkg::sat16(48'(r_e2) + 48'(lp >>> 15));
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/smro_cordic.sv
`default_nettype none
// Vectoring CORDIC, one micro-rotation per cycle
module smro_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [16:0] i_y,
    output logic                    o_done,
    output logic [15:0]             o_angle
);
    localparam int SW = $clog2(CORDIC_STEPS + 1);
    logic signed [34:0] r_x, r_y;
    logic [31:0]        r_z;
    logic [SW-1:0]      r_i;
    logic               r_busy, r_done;
    logic signed [34:0] sx, sy, x0, y0;
    logic [31:0]        zsum;

    always_comb begin
        sx = r_x >>> r_i;
        sy = r_y >>> r_i;
        x0 = i_x[15] ? -(35'(i_x) <<< 16) : (35'(i_x) <<< 16);
        y0 = i_x[15] ? -(35'(i_y) <<< 16) : (35'(i_y) <<< 16);
        zsum = r_z + 32'h8000;
    end
    assign o_done = r_done;
    assign o_angle = zsum[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_i <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x <= x0; r_y <= y0; r_i <= '0;
                if (i_x == '0 && i_y == '0) begin
                    r_z <= 32'hFFFF8000;   // rounds to zero
                    r_done <= 1'b1;
                end else begin
                    r_z <= i_x[15] ? 32'h80000000 : 32'h0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + sy; r_y <= r_y - sx;
                    r_z <= r_z + smro_pkg::ATAN_TURNS[5'(r_i)];
                end else begin
                    r_x <= r_x - sy; r_y <= r_y + sx;
                    r_z <= r_z - smro_pkg::ATAN_TURNS[5'(r_i)];
                end
                r_i <= r_i + 1'b1;
                if (r_i == SW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/smro_speed.sv
`default_nettype none
// Merge stage: angle offset, window speed, smoothing and next coefficient
module smro_speed #(
    parameter int SPEED_WINDOW = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire smro_pkg::t_cfg i_cfg,
    input  wire logic           i_start,
    input  wire logic [15:0]    i_raw_angle,
    output logic                o_done,
    output logic [15:0]         o_angle,
    output logic signed [23:0]  o_held,
    output logic signed [23:0]  o_smooth,
    output logic [14:0]         o_coef
);
    typedef enum logic [1:0] {S_IDLE, S_SMOOTH, S_COEF} t_state;
    t_state             r_state;
    logic [15:0]        r_last;
    logic signed [23:0] r_sum, r_held, r_smooth;
    logic [7:0]         r_tick;
    logic [14:0]        r_coef;
    logic               r_done;
    logic [15:0]        ang, d;
    logic signed [17:0] delta;
    logic signed [23:0] n_sum;
    logic [7:0]         n_tick;
    logic signed [42:0] sd;
    logic [23:0]        mag;
    logic [39:0]        prod;
    logic [23:0]        k;

    always_comb begin
        ang = i_raw_angle + i_cfg.angle_offset;
        d = ang - r_last;
        delta = (d > 16'd32768) ? 18'(d) - 18'sd65536 : 18'(d);
        n_sum = r_sum + 24'(delta);
        n_tick = r_tick + 8'd1;
        sd = $signed({1'b0, smro_pkg::SMOOTH_Q16}) * (43'(r_held) - 43'(r_smooth))
             + 43'sd32768;
        mag = r_smooth[23] ? 24'(-r_smooth) : 24'(r_smooth);
        prod = 40'(mag) * 40'(i_cfg.filter_speed_scale);
        k = prod[39:16];
    end
    assign o_done = r_done;
    assign o_held = r_held;
    assign o_smooth = r_smooth;
    assign o_coef = r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_done <= 1'b0;
            r_last <= '0; r_sum <= '0; r_tick <= '0;
            r_held <= '0; r_smooth <= '0;
            r_coef <= i_cfg.filter_coef_floor;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    o_angle <= ang;
                    r_last <= ang;
                    if (n_tick >= 8'(SPEED_WINDOW)) begin
                        r_held <= n_sum; r_sum <= '0; r_tick <= '0;
                    end else begin
                        r_sum <= n_sum; r_tick <= n_tick;
                    end
                    r_state <= S_SMOOTH;
                end
                S_SMOOTH: begin
                    r_smooth <= r_smooth + 24'(sd >>> 16);
                    r_state <= S_COEF;
                end
                S_COEF: begin
                    if (k < 24'(i_cfg.filter_coef_floor)) r_coef <= i_cfg.filter_coef_floor;
                    else if (k > 24'(smro_pkg::COEF_MAX)) r_coef <= smro_pkg::COEF_MAX;
                    else r_coef <= k[14:0];
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
